[hdl/ray_mesh_closest_hit_defines.svh]
// Assertion macros shared by the checker files of the closest-hit block.
// Needs a clock i_clk and an active-low reset i_rst_n in the using scope.
`ifndef RAY_MESH_CLOSEST_HIT_DEFINES_SVH
`define RAY_MESH_CLOSEST_HIT_DEFINES_SVH

// same-cycle implication
`define RMCH_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("rmch check failed");

// next-cycle implication
`define RMCH_ASSERT_NXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("rmch check failed");

`endif

[hdl/rmch_pkg.sv]
// Package of the closest-hit block: payload types, codes, widths, op table.
// Used by every module of the block; depends on nothing.
package rmch_pkg;

    localparam int MAX_FACES = 64;
    localparam int FACE_W    = 6;
    localparam int CNT_W     = 7;
    localparam int COORD_W   = 32;
    localparam int EW        = COORD_W + 1;
    localparam int BW        = EW + 1;
    localparam int PW        = 2 * EW + 1;
    localparam int AW        = 104;
    localparam int QBITS     = 36;
    localparam int QW        = QBITS + 1;
    localparam int ADDR_W    = 8;
    localparam int DEPTH     = MAX_FACES * 3;
    localparam int OP_W      = 6;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] CORNER_LAST = 2'd2;

    localparam logic [1:0] CFG_FACE_COUNT = 2'd0;
    localparam logic [1:0] CFG_CERT_EPS   = 2'd1;
    localparam logic [1:0] CFG_END_CHECK  = 2'd2;
    localparam logic [31:0] EPS_RESET     = 32'd4295;

    localparam logic [CNT_W-1:0] FACE_LIMIT = CNT_W'(MAX_FACES);
    localparam logic [QW-1:0]    ONE_Q32    = QW'(64'h1_0000_0000);
    localparam logic [QW-1:0]    Q_OVER     = QW'(1) << QBITS;
    localparam logic [OP_W-1:0]  MOP_LAST   = 6'd35;

    localparam logic [4:0] SEL_DX = 5'd0,  SEL_DY = 5'd1,  SEL_DZ = 5'd2;
    localparam logic [4:0] SEL_E1X = 5'd3, SEL_E1Y = 5'd4, SEL_E1Z = 5'd5;
    localparam logic [4:0] SEL_E2X = 5'd6, SEL_E2Y = 5'd7, SEL_E2Z = 5'd8;
    localparam logic [4:0] SEL_SX = 5'd9,  SEL_SY = 5'd10, SEL_SZ = 5'd11;
    localparam logic [4:0] SEL_PX_LO = 5'd16, SEL_PX_HI = 5'd17;
    localparam logic [4:0] SEL_PY_LO = 5'd18, SEL_PY_HI = 5'd19;
    localparam logic [4:0] SEL_PZ_LO = 5'd20, SEL_PZ_HI = 5'd21;
    localparam logic [4:0] SEL_QX_LO = 5'd22, SEL_QX_HI = 5'd23;
    localparam logic [4:0] SEL_QY_LO = 5'd24, SEL_QY_HI = 5'd25;
    localparam logic [4:0] SEL_QZ_LO = 5'd26, SEL_QZ_HI = 5'd27;

    localparam logic [3:0] DST_P0 = 4'd0, DST_P1 = 4'd1, DST_P2 = 4'd2;
    localparam logic [3:0] DST_Q0 = 4'd3, DST_Q1 = 4'd4, DST_Q2 = 4'd5;
    localparam logic [3:0] DST_DET = 4'd6, DST_NU = 4'd7, DST_NV = 4'd8, DST_NT = 4'd9;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_MAC, S_DRAIN, S_CHECK, S_DSTART, S_DWAIT, S_EVAL, S_DONE
    } t_state;

    typedef struct packed {
        logic                      op;
        logic [5:0]                face_slot;
        logic [1:0]                corner;
        logic signed [COORD_W-1:0] vert_x;
        logic signed [COORD_W-1:0] vert_y;
        logic signed [COORD_W-1:0] vert_z;
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
    } t_in_item;

    typedef struct packed {
        logic        hit;
        logic [5:0]  hit_face;
        logic [16:0] hit_t;
        logic [6:0]  hit_count;
        logic        uncertain;
    } t_out_item;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } t_corner;

    typedef logic [2:0][EW-1:0] t_v33;
    typedef logic [2:0][PW-1:0] t_v67;

    typedef struct packed {
        logic [4:0] sa;
        logic [4:0] sb;
        logic       first;
        logic       last;
        logic       neg;
        logic [3:0] dest;
    } t_mop;

    typedef struct packed {
        logic       vld;
        logic       first;
        logic       last;
        logic       neg;
        logic       sh;
        logic [3:0] dest;
    } t_mac_ctl;

    typedef struct packed {
        logic       vld;
        logic [3:0] dest;
    } t_mac_wb;

    typedef struct packed {
        logic          done;
        logic [QW-1:0] q;
    } t_div_res;

    function automatic t_mop mop_mk(input logic [4:0] sa, input logic [4:0] sb,
                                    input logic first, input logic last,
                                    input logic neg, input logic [3:0] dest);
        t_mop m;
        m.sa = sa; m.sb = sb; m.first = first; m.last = last; m.neg = neg; m.dest = dest;
        return m;
    endfunction

    // p = d x e2, q = s x e1, then det = e1.p, nu = s.p, nv = d.q, nt = e2.q
    function automatic t_mop mop_rom(input logic [OP_W-1:0] idx);
        t_mop m;
        m = mop_mk(SEL_DX, SEL_DX, 1'b0, 1'b0, 1'b0, DST_P0);
        case (idx)
            6'd0:  m = mop_mk(SEL_DY, SEL_E2Z, 1'b1, 1'b0, 1'b0, DST_P0);
            6'd1:  m = mop_mk(SEL_DZ, SEL_E2Y, 1'b0, 1'b1, 1'b1, DST_P0);
            6'd2:  m = mop_mk(SEL_DZ, SEL_E2X, 1'b1, 1'b0, 1'b0, DST_P1);
            6'd3:  m = mop_mk(SEL_DX, SEL_E2Z, 1'b0, 1'b1, 1'b1, DST_P1);
            6'd4:  m = mop_mk(SEL_DX, SEL_E2Y, 1'b1, 1'b0, 1'b0, DST_P2);
            6'd5:  m = mop_mk(SEL_DY, SEL_E2X, 1'b0, 1'b1, 1'b1, DST_P2);
            6'd6:  m = mop_mk(SEL_SY, SEL_E1Z, 1'b1, 1'b0, 1'b0, DST_Q0);
            6'd7:  m = mop_mk(SEL_SZ, SEL_E1Y, 1'b0, 1'b1, 1'b1, DST_Q0);
            6'd8:  m = mop_mk(SEL_SZ, SEL_E1X, 1'b1, 1'b0, 1'b0, DST_Q1);
            6'd9:  m = mop_mk(SEL_SX, SEL_E1Z, 1'b0, 1'b1, 1'b1, DST_Q1);
            6'd10: m = mop_mk(SEL_SX, SEL_E1Y, 1'b1, 1'b0, 1'b0, DST_Q2);
            6'd11: m = mop_mk(SEL_SY, SEL_E1X, 1'b0, 1'b1, 1'b1, DST_Q2);
            6'd12: m = mop_mk(SEL_E1X, SEL_PX_LO, 1'b1, 1'b0, 1'b0, DST_DET);
            6'd13: m = mop_mk(SEL_E1X, SEL_PX_HI, 1'b0, 1'b0, 1'b0, DST_DET);
            6'd14: m = mop_mk(SEL_E1Y, SEL_PY_LO, 1'b0, 1'b0, 1'b0, DST_DET);
            6'd15: m = mop_mk(SEL_E1Y, SEL_PY_HI, 1'b0, 1'b0, 1'b0, DST_DET);
            6'd16: m = mop_mk(SEL_E1Z, SEL_PZ_LO, 1'b0, 1'b0, 1'b0, DST_DET);
            6'd17: m = mop_mk(SEL_E1Z, SEL_PZ_HI, 1'b0, 1'b1, 1'b0, DST_DET);
            6'd18: m = mop_mk(SEL_SX, SEL_PX_LO, 1'b1, 1'b0, 1'b0, DST_NU);
            6'd19: m = mop_mk(SEL_SX, SEL_PX_HI, 1'b0, 1'b0, 1'b0, DST_NU);
            6'd20: m = mop_mk(SEL_SY, SEL_PY_LO, 1'b0, 1'b0, 1'b0, DST_NU);
            6'd21: m = mop_mk(SEL_SY, SEL_PY_HI, 1'b0, 1'b0, 1'b0, DST_NU);
            6'd22: m = mop_mk(SEL_SZ, SEL_PZ_LO, 1'b0, 1'b0, 1'b0, DST_NU);
            6'd23: m = mop_mk(SEL_SZ, SEL_PZ_HI, 1'b0, 1'b1, 1'b0, DST_NU);
            6'd24: m = mop_mk(SEL_DX, SEL_QX_LO, 1'b1, 1'b0, 1'b0, DST_NV);
            6'd25: m = mop_mk(SEL_DX, SEL_QX_HI, 1'b0, 1'b0, 1'b0, DST_NV);
            6'd26: m = mop_mk(SEL_DY, SEL_QY_LO, 1'b0, 1'b0, 1'b0, DST_NV);
            6'd27: m = mop_mk(SEL_DY, SEL_QY_HI, 1'b0, 1'b0, 1'b0, DST_NV);
            6'd28: m = mop_mk(SEL_DZ, SEL_QZ_LO, 1'b0, 1'b0, 1'b0, DST_NV);
            6'd29: m = mop_mk(SEL_DZ, SEL_QZ_HI, 1'b0, 1'b1, 1'b0, DST_NV);
            6'd30: m = mop_mk(SEL_E2X, SEL_QX_LO, 1'b1, 1'b0, 1'b0, DST_NT);
            6'd31: m = mop_mk(SEL_E2X, SEL_QX_HI, 1'b0, 1'b0, 1'b0, DST_NT);
            6'd32: m = mop_mk(SEL_E2Y, SEL_QY_LO, 1'b0, 1'b0, 1'b0, DST_NT);
            6'd33: m = mop_mk(SEL_E2Y, SEL_QY_HI, 1'b0, 1'b0, 1'b0, DST_NT);
            6'd34: m = mop_mk(SEL_E2Z, SEL_QZ_LO, 1'b0, 1'b0, 1'b0, DST_NT);
            6'd35: m = mop_mk(SEL_E2Z, SEL_QZ_HI, 1'b0, 1'b1, 1'b0, DST_NT);
            default: m = mop_mk(SEL_DX, SEL_DX, 1'b0, 1'b0, 1'b0, DST_P0);
        endcase
        return m;
    endfunction

endpackage

[hdl/rmch_store.sv]
// Triangle corner store: one corner (x, y, z) per entry, one write and one read port.
// Depends on rmch_pkg.
module rmch_store (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [rmch_pkg::ADDR_W-1:0] i_waddr,
    input  rmch_pkg::t_corner           i_wdata,
    input  logic [rmch_pkg::ADDR_W-1:0] i_raddr,
    output rmch_pkg::t_corner           o_rdata
);
    import rmch_pkg::*;

    t_corner r_mem [DEPTH];
    t_corner r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/rmch_mac.sv]
// Multiply-accumulate unit: registered 34x34 signed product, then shifted accumulate.
// Depends on rmch_pkg.
module rmch_mac (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic signed [rmch_pkg::BW-1:0] i_a,
    input  logic signed [rmch_pkg::BW-1:0] i_b,
    input  rmch_pkg::t_mac_ctl            i_ctl,
    output rmch_pkg::t_mac_wb             o_wb,
    output logic [rmch_pkg::AW-1:0]       o_acc
);
    import rmch_pkg::*;

    logic signed [2*BW-1:0] r_prod;
    t_mac_ctl               r_ctl;
    logic [AW-1:0]          r_acc;
    logic [AW-1:0]          term;
    logic [AW-1:0]          n_acc;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        if (r_ctl.vld) begin
            r_acc <= n_acc;
        end
    end

    always_comb begin
        term = {{(AW-2*BW){r_prod[2*BW-1]}}, r_prod};
        if (r_ctl.sh) begin
            term = term << EW;
        end
        if (r_ctl.neg) begin
            term = -term;
        end
        n_acc = (r_ctl.first ? '0 : r_acc) + term;
    end

    assign o_wb  = '{vld: r_ctl.vld & r_ctl.last, dest: r_ctl.dest};
    assign o_acc = n_acc;

endmodule

[hdl/rmch_div.sv]
// Restoring divider: floor(num * 2^32 / den), one quotient bit per cycle, over flag on top bit.
// Depends on rmch_pkg.
module rmch_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rmch_pkg::AW-1:0]   i_num,
    input  logic [rmch_pkg::AW-1:0]   i_den,
    output rmch_pkg::t_div_res        o_res
);
    import rmch_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic             r_over;
    logic [5:0]       r_cnt;
    logic [AW-1:0]    r_rem;
    logic [AW-1:0]    r_den;
    logic [QBITS-1:0] r_feed;
    logic [QBITS-1:0] r_q;

    logic             over;
    logic [AW:0]      rem2;
    logic [AW+1:0]    diff;
    logic             ge;

    assign over = {4'b0, i_num} >= {i_den, 4'b0};
    assign rem2 = {r_rem, r_feed[QBITS-1]};
    assign diff = {1'b0, rem2} - {2'b0, r_den};
    assign ge   = !diff[AW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= !over;
                r_done <= over;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_over <= over;
            r_cnt  <= 6'(QBITS - 1);
            r_rem  <= i_num >> 4;
            r_feed <= {i_num[3:0], 32'b0};
            r_den  <= i_den;
            r_q    <= '0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 6'd1;
            r_rem  <= ge ? diff[AW-1:0] : rem2[AW-1:0];
            r_feed <= r_feed << 1;
            r_q    <= {r_q[QBITS-2:0], ge};
        end
    end

    assign o_res = '{done: r_done, q: r_over ? Q_OVER : {1'b0, r_q}};

endmodule

[hdl/ray_mesh_closest_hit.sv]
// Top level of the closest-hit block: sequencer, operand registers, hit bookkeeping.
// Depends on rmch_pkg, rmch_store, rmch_mac and rmch_div.
//
//  channel | valid       | stall       | payload
//  input   | i_in_valid  | o_in_stall  | i_in_data  (load corner or query)
//  output  | o_out_valid | i_out_stall | o_out_data (one per query)
//
// A query works face by face. Every face takes 4 store reads and 36 passes through
// the one multiplier; a face rejected on det or sign ends there, while a face that
// needs its three quotients runs three divisions (a quotient out of range is flagged
// at the start of its division, which then does not run).
// Reset clears control and configuration; the store is not cleared.
// A finished result waits in the output register; loads and queries are taken meanwhile.
module ray_mesh_closest_hit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  rmch_pkg::t_in_item  i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output rmch_pkg::t_out_item o_out_data,
    input  logic                i_out_stall,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import rmch_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_face_count;
    logic [31:0]      r_eps;
    logic             r_end_chk;

    logic [FACE_W-1:0] r_face;
    logic [CNT_W-1:0]  r_nf;
    logic [1:0]        r_k;
    logic [OP_W-1:0]   r_op;
    logic [1:0]        r_dsel;

    t_corner r_org;
    t_corner r_v1;
    t_v33    r_dv, r_e1, r_e2, r_s;
    t_v67    r_p, r_q;
    logic [AW-1:0] r_det, r_nu, r_nv, r_nt;
    logic [QW-1:0] r_u, r_v, r_t;

    logic              r_any;
    logic [32:0]       r_best_t;
    logic [FACE_W-1:0] r_best_face;
    logic [CNT_W-1:0]  r_count;
    logic              r_unc;

    logic      r_out_valid;
    t_out_item r_out;

    logic              in_xfer, in_load, in_query, mem_we, out_load, div_start;
    logic [ADDR_W-1:0] waddr, raddr;
    t_corner           rdata;
    t_mop              mop;
    t_mac_ctl          mac_ctl;
    t_mac_wb           mac_wb;
    logic [AW-1:0]     mac_acc;
    t_div_res          div_res;
    logic [EW-1:0]     a33;
    logic [PW-1:0]     pq;
    logic [BW-1:0]     op_a, op_b;
    logic [AW-1:0]     det_n, nu_n, nv_n, nt_n, div_num;
    logic              reject, last_face;
    logic [QW:0]       uv;
    logic [QW:0]       w_rest;
    logic [QW-1:0]     t_rest;
    logic [QW-1:0]     eps_x;
    logic              hit, unc;
    logic [CNT_W-1:0]  nf_in;

    function automatic logic [EW-1:0] sub33(input logic [COORD_W-1:0] a,
                                            input logic [COORD_W-1:0] b);
        return {a[COORD_W-1], a} - {b[COORD_W-1], b};
    endfunction

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign in_load  = in_xfer && i_in_data.op == OP_LOAD;
    assign in_query = in_xfer && i_in_data.op == OP_QUERY;
    assign mem_we   = in_load && i_in_data.corner <= CORNER_LAST;
    assign waddr    = {1'b0, i_in_data.face_slot, 1'b0} + {2'b0, i_in_data.face_slot}
                    + {6'b0, i_in_data.corner};
    assign raddr    = {1'b0, r_face, 1'b0} + {2'b0, r_face} + {6'b0, r_k};
    assign nf_in    = r_face_count > FACE_LIMIT ? FACE_LIMIT : r_face_count;
    assign last_face = ({1'b0, r_face} + 7'd1) == r_nf;

    rmch_store u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (waddr),
        .i_wdata ('{x: i_in_data.vert_x, y: i_in_data.vert_y, z: i_in_data.vert_z}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // operand select for the multiplier
    assign mop = mop_rom(r_op);

    always_comb begin
        case (mop.sa)
            SEL_DX:  a33 = r_dv[0];
            SEL_DY:  a33 = r_dv[1];
            SEL_DZ:  a33 = r_dv[2];
            SEL_E1X: a33 = r_e1[0];
            SEL_E1Y: a33 = r_e1[1];
            SEL_E1Z: a33 = r_e1[2];
            SEL_E2X: a33 = r_e2[0];
            SEL_E2Y: a33 = r_e2[1];
            SEL_E2Z: a33 = r_e2[2];
            SEL_SX:  a33 = r_s[0];
            SEL_SY:  a33 = r_s[1];
            SEL_SZ:  a33 = r_s[2];
            default: a33 = '0;
        endcase
        op_a = {a33[EW-1], a33};

        case (mop.sb[3:1])
            3'd0:    pq = r_p[0];
            3'd1:    pq = r_p[1];
            3'd2:    pq = r_p[2];
            3'd3:    pq = r_q[0];
            3'd4:    pq = r_q[1];
            default: pq = r_q[2];
        endcase
        case (mop.sb)
            SEL_E1X: op_b = {r_e1[0][EW-1], r_e1[0]};
            SEL_E1Y: op_b = {r_e1[1][EW-1], r_e1[1]};
            SEL_E1Z: op_b = {r_e1[2][EW-1], r_e1[2]};
            SEL_E2X: op_b = {r_e2[0][EW-1], r_e2[0]};
            SEL_E2Y: op_b = {r_e2[1][EW-1], r_e2[1]};
            SEL_E2Z: op_b = {r_e2[2][EW-1], r_e2[2]};
            default: op_b = mop.sb[0] ? pq[PW-1:EW] : {1'b0, pq[EW-1:0]};
        endcase

        mac_ctl.vld   = r_state == S_MAC;
        mac_ctl.first = mop.first;
        mac_ctl.last  = mop.last;
        mac_ctl.neg   = mop.neg;
        mac_ctl.sh    = mop.sb[4] & mop.sb[0];
        mac_ctl.dest  = mop.dest;
    end

    rmch_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_a     (op_a),
        .i_b     (op_b),
        .i_ctl   (mac_ctl),
        .o_wb    (mac_wb),
        .o_acc   (mac_acc)
    );

    // sign normalization and early reject
    always_comb begin
        det_n  = r_det[AW-1] ? -r_det : r_det;
        nu_n   = r_det[AW-1] ? -r_nu  : r_nu;
        nv_n   = r_det[AW-1] ? -r_nv  : r_nv;
        nt_n   = r_det[AW-1] ? -r_nt  : r_nt;
        reject = r_det == '0 || nu_n[AW-1] || nv_n[AW-1] || nt_n[AW-1];
        unique case (r_dsel)
            2'd0:    div_num = r_nu;
            2'd1:    div_num = r_nv;
            default: div_num = r_nt;
        endcase
    end

    assign div_start = r_state == S_DSTART;

    rmch_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_det),
        .o_res   (div_res)
    );

    // hit test on the quotients
    always_comb begin
        uv     = {1'b0, r_u} + {1'b0, r_v};
        w_rest = {1'b0, ONE_Q32} - uv;
        t_rest = ONE_Q32 - r_t;
        eps_x  = {5'b0, r_eps};
        hit    = uv <= {1'b0, ONE_Q32} && r_t <= ONE_Q32;
        unc    = r_u <= eps_x || r_v <= eps_x || w_rest[QW-1:0] <= eps_x || r_t <= eps_x
               || (r_end_chk && t_rest <= eps_x);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_query) begin
                    n_state = nf_in == '0 ? S_DONE : S_READ;
                end
            end
            S_READ: begin
                if (r_k == 2'd3) begin
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                if (r_op == MOP_LAST) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_CHECK;
            S_CHECK: begin
                if (!reject) begin
                    n_state = S_DSTART;
                end else begin
                    n_state = last_face ? S_DONE : S_READ;
                end
            end
            S_DSTART: n_state = S_DWAIT;
            S_DWAIT: begin
                if (div_res.done) begin
                    n_state = r_dsel == 2'd2 ? S_EVAL : S_DSTART;
                end
            end
            S_EVAL: n_state = last_face ? S_DONE : S_READ;
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_count <= '0;
            r_eps        <= EPS_RESET;
            r_end_chk    <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FACE_COUNT: r_face_count <= i_cfg_data[CNT_W-1:0];
                    CFG_CERT_EPS:   r_eps        <= i_cfg_data;
                    CFG_END_CHECK:  r_end_chk    <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= '{hit: r_any, hit_face: r_best_face, hit_t: r_best_t[32:16],
                       hit_count: r_count, uncertain: r_unc};
        end

        if (mac_wb.vld) begin
            case (mac_wb.dest)
                DST_P0:  r_p[0] <= mac_acc[PW-1:0];
                DST_P1:  r_p[1] <= mac_acc[PW-1:0];
                DST_P2:  r_p[2] <= mac_acc[PW-1:0];
                DST_Q0:  r_q[0] <= mac_acc[PW-1:0];
                DST_Q1:  r_q[1] <= mac_acc[PW-1:0];
                DST_Q2:  r_q[2] <= mac_acc[PW-1:0];
                DST_DET: r_det  <= mac_acc;
                DST_NU:  r_nu   <= mac_acc;
                DST_NV:  r_nv   <= mac_acc;
                DST_NT:  r_nt   <= mac_acc;
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                r_k    <= '0;
                r_face <= '0;
                r_nf   <= nf_in;
                if (in_query) begin
                    r_org.x     <= i_in_data.origin_x;
                    r_org.y     <= i_in_data.origin_y;
                    r_org.z     <= i_in_data.origin_z;
                    r_dv[0]     <= {i_in_data.dir_x[COORD_W-1], i_in_data.dir_x};
                    r_dv[1]     <= {i_in_data.dir_y[COORD_W-1], i_in_data.dir_y};
                    r_dv[2]     <= {i_in_data.dir_z[COORD_W-1], i_in_data.dir_z};
                    r_any       <= 1'b0;
                    r_best_t    <= '0;
                    r_best_face <= '0;
                    r_count     <= '0;
                    r_unc       <= 1'b0;
                end
            end
            S_READ: begin
                r_k  <= r_k + 2'd1;
                r_op <= '0;
                if (r_k == 2'd1) begin
                    r_v1    <= rdata;
                    r_s[0]  <= sub33(r_org.x, rdata.x);
                    r_s[1]  <= sub33(r_org.y, rdata.y);
                    r_s[2]  <= sub33(r_org.z, rdata.z);
                end
                if (r_k == 2'd2) begin
                    r_e1[0] <= sub33(rdata.x, r_v1.x);
                    r_e1[1] <= sub33(rdata.y, r_v1.y);
                    r_e1[2] <= sub33(rdata.z, r_v1.z);
                end
                if (r_k == 2'd3) begin
                    r_e2[0] <= sub33(rdata.x, r_v1.x);
                    r_e2[1] <= sub33(rdata.y, r_v1.y);
                    r_e2[2] <= sub33(rdata.z, r_v1.z);
                end
            end
            S_MAC: r_op <= r_op + 6'd1;
            S_DRAIN: ;
            S_CHECK: begin
                r_det  <= det_n;
                r_nu   <= nu_n;
                r_nv   <= nv_n;
                r_nt   <= nt_n;
                r_dsel <= '0;
                r_k    <= '0;
                if (reject && !last_face) begin
                    r_face <= r_face + 6'd1;
                end
            end
            S_DSTART: ;
            S_DWAIT: begin
                if (div_res.done) begin
                    r_dsel <= r_dsel + 2'd1;
                    unique case (r_dsel)
                        2'd0:    r_u <= div_res.q;
                        2'd1:    r_v <= div_res.q;
                        default: r_t <= div_res.q;
                    endcase
                end
            end
            S_EVAL: begin
                r_k <= '0;
                if (hit) begin
                    r_count <= r_count + 7'd1;
                    r_unc   <= r_unc | unc;
                    if (!r_any || r_t[32:0] < r_best_t) begin
                        r_any       <= 1'b1;
                        r_best_t    <= r_t[32:0];
                        r_best_face <= r_face;
                    end
                end
                if (!last_face) begin
                    r_face <= r_face + 6'd1;
                end
            end
            S_DONE: ;
            default: ;
        endcase
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[hdl/rmch_checker.sv]
// Port-level checker of the closest-hit block, bound to the top level.
// Depends on rmch_pkg and ray_mesh_closest_hit_defines.svh.
`include "ray_mesh_closest_hit_defines.svh"

module rmch_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input rmch_pkg::t_in_item  i_in_data,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input rmch_pkg::t_out_item o_out_data,
    input logic                i_out_stall
);
    import rmch_pkg::*;

    `RMCH_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))
    `RMCH_ASSERT_IMP(a_miss_clean, o_out_valid && !o_out_data.hit, o_out_data.hit_face == 6'd0 && o_out_data.hit_t == 17'd0 && o_out_data.hit_count == 7'd0 && !o_out_data.uncertain)
    `RMCH_ASSERT_IMP(a_hit_counted, o_out_valid && o_out_data.hit, o_out_data.hit_count != 7'd0 && o_out_data.hit_count <= 7'd64 && o_out_data.hit_t <= 17'h10000)
    `RMCH_ASSERT_IMP(a_busy_after_query, $rose(o_in_stall), $past(i_in_valid) && $past(i_in_data.op) == OP_QUERY)

endmodule

bind ray_mesh_closest_hit rmch_checker u_rmch_checker (.*);
